[design/clt_pkg.sv]
// Shared types and constants for the command line tokeniser.
package clt_pkg;

  localparam int MaxArgsDefault = 64;

  // Result queue depth: room for the two results of one byte on top of two results already held.
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // Scan modes
  localparam logic [2:0] M_BETWEEN = 3'd0;
  localparam logic [2:0] M_PLAIN   = 3'd1;
  localparam logic [2:0] M_PESC    = 3'd2;
  localparam logic [2:0] M_SQUOTE  = 3'd3;
  localparam logic [2:0] M_DQUOTE  = 3'd4;
  localparam logic [2:0] M_DESC    = 3'd5;

  localparam logic [7:0] CH_DQ = 8'h22;
  localparam logic [7:0] CH_SQ = 8'h27;
  localparam logic [7:0] CH_BS = 8'h5C;
  localparam logic [7:0] CH_NL = 8'h0A;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } byte_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       has_char;
    logic       arg_end;
    logic [5:0] arg_index;
    logic       line_done;
    logic [5:0] arg_total;
    logic       run_last;
  } tok_t;

  // Up to two results produced by one input byte
  typedef struct packed {
    logic [1:0] n;
    tok_t       r0;
    tok_t       r1;
  } res_pair_t;

  function automatic logic is_blank(input logic [7:0] b);
    return ((b >= 8'd9) && (b <= 8'd13)) || (b == 8'd32);
  endfunction

endpackage

[design/clt_decode.sv]
// Combinational step of the tokeniser: one byte and the scan state in, results and next state out.
module clt_decode import clt_pkg::*; #(
  parameter int MAX_ARGS = MaxArgsDefault
) (
  input  byte_t                          cur,
  input  logic [2:0]                     mode,
  input  logic [$clog2(MAX_ARGS)-1:0]    cnt,
  output logic [2:0]                     mode_next,
  output logic [$clog2(MAX_ARGS)-1:0]    cnt_next,
  output res_pair_t                      res
);

  localparam int CntW = $clog2(MAX_ARGS);

  logic [7:0]      b;
  logic            last;
  logic [2:0]      mode_eff;
  logic [2:0]      mode_new;
  logic [CntW-1:0] cnt_new;
  logic [7:0]      ch0;
  logic [7:0]      ch1;
  logic [1:0]      nch;
  logic            ended;
  logic            ended_all;
  logic [1:0]      count;
  logic [CntW-1:0] cnt_m1;
  logic [CntW+5:0] idx_ext;
  logic [CntW+5:0] tot_ext;
  logic [5:0]      idx;
  logic [5:0]      total;
  tok_t            fin_r;

  assign b    = cur.in_byte;
  assign last = cur.in_last;
  assign mode_eff = (mode > M_DESC) ? M_BETWEEN : mode;

  always_comb begin
    mode_new = mode_eff;
    cnt_new  = cnt;
    ch0      = 8'd0;
    ch1      = 8'd0;
    nch      = 2'd0;
    ended    = 1'b0;
    unique case (mode_eff)
      M_BETWEEN: begin
        if ((cnt < CntW'(MAX_ARGS - 1)) && !is_blank(b)) begin
          cnt_new = cnt + CntW'(1);
          priority if (b == CH_SQ) begin
            mode_new = M_SQUOTE;
          end else if (b == CH_DQ) begin
            mode_new = M_DQUOTE;
          end else if (b == CH_BS) begin
            if (last) begin
              ch0 = b; nch = 2'd1; mode_new = M_PLAIN;
            end else begin
              mode_new = M_PESC;
            end
          end else begin
            ch0 = b; nch = 2'd1; mode_new = M_PLAIN;
          end
        end
      end
      M_PLAIN: begin
        priority if (is_blank(b)) begin
          ended = 1'b1; mode_new = M_BETWEEN;
        end else if (b == CH_BS) begin
          if (last) begin
            ch0 = b; nch = 2'd1;
          end else begin
            mode_new = M_PESC;
          end
        end else begin
          ch0 = b; nch = 2'd1;
        end
      end
      M_PESC: begin
        ch0 = b; nch = 2'd1; mode_new = M_PLAIN;
      end
      M_SQUOTE: begin
        if (b == CH_SQ) begin
          ended = 1'b1; mode_new = M_BETWEEN;
        end else begin
          ch0 = b; nch = 2'd1;
        end
      end
      M_DQUOTE: begin
        priority if (b == CH_DQ) begin
          ended = 1'b1; mode_new = M_BETWEEN;
        end else if (b == CH_BS) begin
          if (last) begin
            ch0 = b; nch = 2'd1;
          end else begin
            mode_new = M_DESC;
          end
        end else begin
          ch0 = b; nch = 2'd1;
        end
      end
      default: begin
        // escape inside double quotes: only quote, backslash and newline swallow the backslash
        if ((b != CH_DQ) && (b != CH_BS) && (b != CH_NL)) begin
          ch0 = CH_BS; ch1 = b; nch = 2'd2;
        end else begin
          ch0 = b; nch = 2'd1;
        end
        mode_new = M_DQUOTE;
      end
    endcase
  end

  assign ended_all = ended || (last && (mode_new != M_BETWEEN));
  assign count     = ((nch == 2'd0) && (ended_all || last)) ? 2'd1 : nch;

  assign cnt_m1  = cnt_new - CntW'(1);
  assign idx_ext = {6'd0, cnt_m1};
  assign tot_ext = {6'd0, cnt_new};
  assign idx     = (cnt_new != '0) ? idx_ext[5:0] : 6'd0;
  assign total   = tot_ext[5:0];

  // final result of the item carries the flags
  always_comb begin
    fin_r.has_char  = (count == 2'd2) || (nch == 2'd1);
    fin_r.out_char  = (count == 2'd2) ? ch1 : ((nch == 2'd1) ? ch0 : 8'd0);
    fin_r.arg_end   = ended_all;
    fin_r.arg_index = (fin_r.has_char || ended_all) ? idx : 6'd0;
    fin_r.line_done = last;
    fin_r.arg_total = last ? total : 6'd0;
    fin_r.run_last  = 1'b1;
  end

  always_comb begin
    res.n  = count;
    res.r0 = fin_r;
    res.r1 = fin_r;
    if (count == 2'd2) begin
      res.r0.out_char  = ch0;
      res.r0.has_char  = 1'b1;
      res.r0.arg_end   = 1'b0;
      res.r0.arg_index = idx;
      res.r0.line_done = 1'b0;
      res.r0.arg_total = 6'd0;
      res.r0.run_last  = 1'b0;
    end
  end

  assign mode_next = last ? M_BETWEEN : mode_new;
  assign cnt_next  = last ? '0 : cnt_new;

endmodule

[design/clt_fifo.sv]
// Small result queue: takes up to two results per cycle, hands out one per cycle while tok_stall is low.
module clt_fifo import clt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  res_pair_t        wr_data,
  input  logic             tok_stall,
  output logic             tok_valid,
  output tok_t             tok_data,
  output logic             room
);

  tok_t             mem [QDepth];
  logic [QPtrW-1:0] head;
  logic [QPtrW-1:0] tail;
  logic [QCntW-1:0] count;
  logic [QCntW-1:0] n_in;
  logic             pop;

  assign tok_valid = (count != '0);
  assign tok_data  = mem[head];
  assign pop       = tok_valid && !tok_stall;
  assign room      = (count <= QCntW'(QDepth - 2));
  assign n_in      = wr ? QCntW'(wr_data.n) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail + QPtrW'(n_in);
      count <= count + n_in - QCntW'(pop);
      if (pop) begin
        head <= head + QPtrW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      if (wr_data.n == 2'd2) begin
        mem[tail]                <= wr_data.r0;
        mem[tail + QPtrW'(1)]    <= wr_data.r1;
      end else if (wr_data.n == 2'd1) begin
        mem[tail]                <= wr_data.r1;
      end
    end
  end

endmodule

[design/command_line_tokenizer_top.sv]
// Command line tokeniser: takes one byte per cycle through an input register; the byte is
// decoded in one pass and its results, up to two, enter a four-entry result queue, so a byte
// can be taken every cycle while the output side keeps up. A byte inside double quotes that
// follows a backslash and is not a quote, backslash or newline gives two results, handed out
// one after the other. Bytes that give no result cost nothing downstream.
module command_line_tokenizer_top import clt_pkg::*; #(
  parameter int MAX_ARGS = MaxArgsDefault
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  byte_valid,
  output logic  byte_stall,
  input  byte_t byte_data,
  output logic  tok_valid,
  input  logic  tok_stall,
  output tok_t  tok_data
);

  localparam int CntW = $clog2(MAX_ARGS);

  logic            in_full;
  byte_t           in_q;
  logic            room;
  logic            adv;
  logic [2:0]      mode;
  logic [2:0]      mode_next;
  logic [CntW-1:0] cnt;
  logic [CntW-1:0] cnt_next;
  res_pair_t       res;

  assign adv        = in_full && room;
  assign byte_stall = in_full && !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
      mode    <= M_BETWEEN;
      cnt     <= '0;
    end else begin
      if (!in_full || adv) begin
        in_full <= byte_valid;
      end
      if (adv) begin
        mode <= mode_next;
        cnt  <= cnt_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      in_q <= byte_data;
    end
  end

  clt_decode #(.MAX_ARGS(MAX_ARGS)) u_decode (
    .cur       (in_q),
    .mode      (mode),
    .cnt       (cnt),
    .mode_next (mode_next),
    .cnt_next  (cnt_next),
    .res       (res)
  );

  clt_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr        (adv),
    .wr_data   (res),
    .tok_stall (tok_stall),
    .tok_valid (tok_valid),
    .tok_data  (tok_data),
    .room      (room)
  );

endmodule

[verif/command_line_tokenizer_tb.sv]
// Self-checking testbench for the command line tokeniser, with its own token predictor.
`timescale 1ns / 100ps

module testbench;
  import clt_pkg::*;

  localparam int ClkHalf    = 2;
  localparam int ByteTarget = 950;
  localparam int HoldCycles = 150;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       typed;   // exp below is checked as written
    tok_t       exp;
  } dir_row_t;

  typedef struct {
    byte_t b;
    bit    typed;
    tok_t  exp;
    bit    drain;        // hold back until every token so far has come out
  } line_byte_t;

  localparam tok_t T_NONE = '0;

  // Directed rows: extremes and each quoting rule, typed results right after reset only.
  localparam dir_row_t DIR_ROWS [25] = '{
    '{8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1, 6'd0, 1'b1, 6'd1, 1'b1}},
    '{8'h00, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, 6'd0, 1'b1, 6'd1, 1'b1}},
    '{8'h20, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, 6'd0, 1'b1, 6'd0, 1'b1}},
    '{CH_BS, 1'b1, 1'b1, '{CH_BS, 1'b1, 1'b1, 6'd0, 1'b1, 6'd1, 1'b1}},
    '{8'h20, 1'b0, 1'b0, T_NONE},   // quiet leading blank
    '{8'h61, 1'b0, 1'b0, T_NONE},
    '{8'h09, 1'b0, 1'b0, T_NONE},   // tab closes the word
    '{CH_SQ, 1'b0, 1'b0, T_NONE},
    '{8'h62, 1'b0, 1'b0, T_NONE},
    '{8'h20, 1'b0, 1'b0, T_NONE},   // blank kept inside single quotes
    '{CH_SQ, 1'b0, 1'b0, T_NONE},
    '{CH_DQ, 1'b0, 1'b0, T_NONE},
    '{CH_BS, 1'b0, 1'b0, T_NONE},
    '{8'h6E, 1'b0, 1'b0, T_NONE},   // backslash kept: two tokens
    '{CH_BS, 1'b0, 1'b0, T_NONE},
    '{CH_DQ, 1'b0, 1'b0, T_NONE},   // escaped quote, backslash dropped
    '{CH_BS, 1'b0, 1'b0, T_NONE},
    '{CH_NL, 1'b0, 1'b0, T_NONE},
    '{CH_DQ, 1'b0, 1'b0, T_NONE},
    '{8'h0D, 1'b0, 1'b0, T_NONE},
    '{CH_BS, 1'b0, 1'b0, T_NONE},
    '{8'h20, 1'b0, 1'b0, T_NONE},   // escaped blank in a plain word
    '{CH_BS, 1'b1, 1'b0, T_NONE},   // trailing backslash
    '{CH_DQ, 1'b0, 1'b0, T_NONE},
    '{8'h7A, 1'b1, 1'b0, T_NONE}    // line ends inside an open quote
  };

  logic  clk;
  logic  rst;
  logic  byte_valid;
  logic  byte_stall;
  byte_t byte_data;
  logic  tok_valid;
  logic  tok_stall;
  tok_t  tok_data;

  command_line_tokenizer_top dut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_data  (byte_data),
    .tok_valid  (tok_valid),
    .tok_stall  (tok_stall),
    .tok_data   (tok_data)
  );

  line_byte_t line_q [$];
  logic [7:0] line_buf [$];
  tok_t       tok_expect_q [$];
  line_byte_t cur_byte;
  bit         holding;
  bit         drain_next;

  logic [2:0] tok_mode;
  int         tok_args;

  int errors;
  int gen_bytes;
  int lines_built;
  int bytes_taken;
  int toks_checked;
  int pair_bytes;
  int hold_cnt;
  bit hold_done;

  initial begin
    clk = 1'b0;
    forever #(ClkHalf) clk = ~clk;
  end

  function automatic bit blank_char(logic [7:0] c);
    return (c >= 8'd9 && c <= 8'd13) || c == 8'd32;
  endfunction

  // Works out the tokens one byte gives and queues them; returns how many.
  function automatic int predict_tokens(byte_t it);
    logic [7:0] b;
    logic       last;
    logic [7:0] chars [2];
    int         nch;
    int         count;
    bit         ended;
    logic [5:0] idx;
    tok_t       r;
    b = it.in_byte;
    last = it.in_last;
    nch = 0;
    ended = 0;
    if (tok_mode > M_DESC) tok_mode = M_BETWEEN;
    case (tok_mode)
      M_BETWEEN: begin
        if (tok_args < MaxArgsDefault - 1 && !blank_char(b)) begin
          tok_args++;
          if (b == CH_SQ) tok_mode = M_SQUOTE;
          else if (b == CH_DQ) tok_mode = M_DQUOTE;
          else if (b == CH_BS && !last) tok_mode = M_PESC;
          else begin
            chars[nch++] = b;
            tok_mode = M_PLAIN;
          end
        end
      end
      M_PLAIN: begin
        if (blank_char(b)) begin
          ended = 1;
          tok_mode = M_BETWEEN;
        end else if (b == CH_BS && !last) tok_mode = M_PESC;
        else chars[nch++] = b;
      end
      M_PESC: begin
        chars[nch++] = b;
        tok_mode = M_PLAIN;
      end
      M_SQUOTE: begin
        if (b == CH_SQ) begin
          ended = 1;
          tok_mode = M_BETWEEN;
        end else chars[nch++] = b;
      end
      M_DQUOTE: begin
        if (b == CH_DQ) begin
          ended = 1;
          tok_mode = M_BETWEEN;
        end else if (b == CH_BS && !last) tok_mode = M_DESC;
        else chars[nch++] = b;
      end
      default: begin
        if (b != CH_DQ && b != CH_BS && b != CH_NL) chars[nch++] = CH_BS;
        chars[nch++] = b;
        tok_mode = M_DQUOTE;
      end
    endcase
    if (last && tok_mode != M_BETWEEN) ended = 1;
    count = nch;
    if (count == 0 && (ended || last)) count = 1;
    if (nch == 2) pair_bytes++;
    idx = (tok_args > 0) ? 6'(tok_args - 1) : 6'd0;
    for (int k = 0; k < count; k++) begin
      r = '0;
      if (k < nch) begin
        r.out_char = chars[k];
        r.has_char = 1'b1;
      end
      r.arg_end = (k == count - 1) && ended;
      r.arg_index = (r.has_char || r.arg_end) ? idx : 6'd0;
      r.line_done = (k == count - 1) && last;
      r.arg_total = r.line_done ? 6'(tok_args) : 6'd0;
      r.run_last = (k == count - 1);
      tok_expect_q.push_back(r);
    end
    if (last) begin
      tok_mode = M_BETWEEN;
      tok_args = 0;
    end
    return count;
  endfunction

  task automatic take_byte(line_byte_t s);
    int n;
    n = predict_tokens(s.b);
    if (s.typed) begin
      repeat (n) void'(tok_expect_q.pop_back());
      tok_expect_q.push_back(s.exp);
    end
    bytes_taken++;
  endtask

  task automatic put_byte(logic [7:0] c);
    line_buf.push_back(c);
    gen_bytes++;
  endtask

  task automatic finish_line();
    line_byte_t s;
    for (int i = 0; i < line_buf.size(); i++) begin
      s.b.in_byte = line_buf[i];
      s.b.in_last = (i == line_buf.size() - 1);
      s.typed = 0;
      s.exp = '0;
      s.drain = (i == 0) && drain_next;
      line_q.push_back(s);
    end
    drain_next = 0;
    line_buf.delete();
    lines_built++;
  endtask

  function automatic logic [7:0] blank_byte();
    int r;
    r = $urandom_range(5);
    return (r == 5) ? 8'd32 : 8'(9 + r);
  endfunction

  // A byte that neither separates nor quotes nor escapes.
  function automatic logic [7:0] word_byte();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    while (blank_char(c) || c == CH_SQ || c == CH_DQ || c == CH_BS) c = 8'($urandom_range(255));
    return c;
  endfunction

  task automatic build_plain_word();
    int len;
    len = $urandom_range(1, 6);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(99) < 15) begin
        put_byte(CH_BS);
        put_byte(8'($urandom_range(255)));
      end else put_byte(word_byte());
    end
  endtask

  task automatic build_quoted_word(logic [7:0] q, bit close);
    int         len;
    logic [7:0] c;
    put_byte(q);
    len = $urandom_range(5);
    for (int k = 0; k < len; k++) begin
      if (q == CH_DQ && $urandom_range(9) < 3) begin
        put_byte(CH_BS);
        case ($urandom_range(3))
          0: put_byte(CH_DQ);
          1: put_byte(CH_BS);
          2: put_byte(CH_NL);
          default: put_byte(word_byte());
        endcase
      end else begin
        c = 8'($urandom_range(255));
        while (c == q || c == CH_BS) c = 8'($urandom_range(255));
        put_byte(c);
      end
    end
    if (close) put_byte(q);
  endtask

  task automatic build_line();
    int nw;
    bit close;
    nw = $urandom_range(1, 6);
    for (int w = 0; w < nw; w++) begin
      if (w > 0 || $urandom_range(1)) begin
        repeat ($urandom_range(1, 2)) put_byte(blank_byte());
      end
      close = (w != nw - 1) || ($urandom_range(3) != 0);
      case ($urandom_range(2))
        0: build_plain_word();
        1: build_quoted_word(CH_SQ, close);
        default: build_quoted_word(CH_DQ, close);
      endcase
    end
    case ($urandom_range(9))
      0: put_byte(CH_BS);
      1: put_byte(blank_byte());
      default: ;
    endcase
    finish_line();
  endtask

  task automatic build_noise_line();
    logic [7:0] specials [6];
    specials = '{CH_SQ, CH_DQ, CH_BS, CH_NL, 8'h20, 8'h09};
    repeat ($urandom_range(1, 12)) begin
      if ($urandom_range(9) < 3) put_byte(specials[$urandom_range(5)]);
      else put_byte(8'($urandom_range(255)));
    end
    finish_line();
  endtask

  // More words than the argument limit allows; the tail is dropped.
  task automatic build_crowded_line();
    repeat ($urandom_range(66, 72)) begin
      put_byte(word_byte());
      put_byte(8'h20);
    end
    put_byte(word_byte());
    finish_line();
  endtask

  task automatic build_stimulus();
    line_byte_t s;
    foreach (DIR_ROWS[i]) begin
      s.b.in_byte = DIR_ROWS[i].ch;
      s.b.in_last = DIR_ROWS[i].last;
      s.typed = DIR_ROWS[i].typed;
      s.exp = DIR_ROWS[i].exp;
      s.drain = 0;
      line_q.push_back(s);
    end
    drain_next = 1;
    build_crowded_line();
    while (gen_bytes < ByteTarget) begin
      if (lines_built == 30) begin
        drain_next = 1;
        build_crowded_line();
      end else if ($urandom_range(99) < 15) build_noise_line();
      else build_line();
    end
  endtask

  function automatic bit no_idle_window();
    return bytes_taken >= 550 && bytes_taken < 700;
  endfunction

  // Byte sender
  always @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else begin
      if (byte_valid && !byte_stall) begin
        take_byte(cur_byte);
        holding = 0;
      end
      if (!holding) begin
        if (line_q.size() > 0 && !(line_q[0].drain && tok_expect_q.size() > 0) &&
            (no_idle_window() || $urandom_range(99) >= 20)) begin
          cur_byte = line_q.pop_front();
          holding = 1;
          byte_data <= cur_byte.b;
          byte_valid <= 1'b1;
        end else begin
          byte_valid <= 1'b0;
        end
      end
    end
  end

  // Token receiver, with one long hold-off so the block backs up
  always @(posedge clk) begin
    if (rst) begin
      tok_stall <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      tok_stall <= 1'b1;
    end else if (!hold_done && bytes_taken >= 300) begin
      hold_done = 1;
      hold_cnt = HoldCycles;
      tok_stall <= 1'b1;
    end else begin
      tok_stall <= !no_idle_window() && ($urandom_range(99) < 20);
    end
  end

  // Token checker
  always @(posedge clk) begin
    tok_t want;
    if (!rst && tok_valid && !tok_stall) begin
      if (tok_expect_q.size() == 0) begin
        $error("token with nothing expected: %h", tok_data);
        errors++;
      end else begin
        want = tok_expect_q.pop_front();
        toks_checked++;
        if (tok_data.out_char !== want.out_char) begin
          $error("out_char expected %0h actual %0h", want.out_char, tok_data.out_char);
          errors++;
        end
        if (tok_data.has_char !== want.has_char) begin
          $error("has_char expected %0h actual %0h", want.has_char, tok_data.has_char);
          errors++;
        end
        if (tok_data.arg_end !== want.arg_end) begin
          $error("arg_end expected %0h actual %0h", want.arg_end, tok_data.arg_end);
          errors++;
        end
        if (tok_data.arg_index !== want.arg_index) begin
          $error("arg_index expected %0d actual %0d", want.arg_index, tok_data.arg_index);
          errors++;
        end
        if (tok_data.line_done !== want.line_done) begin
          $error("line_done expected %0h actual %0h", want.line_done, tok_data.line_done);
          errors++;
        end
        if (tok_data.arg_total !== want.arg_total) begin
          $error("arg_total expected %0d actual %0d", want.arg_total, tok_data.arg_total);
          errors++;
        end
        if (tok_data.run_last !== want.run_last) begin
          $error("run_last expected %0h actual %0h", want.run_last, tok_data.run_last);
          errors++;
        end
      end
    end
  end

  initial begin
    #(400000);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst = 1'b1;
    byte_valid = 1'b0;
    byte_data = '0;
    tok_stall = 1'b0;
    tok_mode = M_BETWEEN;
    tok_args = 0;
    build_stimulus();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk); while (line_q.size() > 0 || holding);
    do @(posedge clk); while (tok_expect_q.size() > 0);
    repeat (16) @(posedge clk);
    if (tok_expect_q.size() > 0) begin
      $error("%0d tokens never arrived", tok_expect_q.size());
      errors++;
    end
    $display("%0d bytes in %0d lines taken, %0d tokens checked, %0d two-token escapes",
             bytes_taken, lines_built, toks_checked, pair_bytes);
    $display("covered quoting, escapes, line ends, argument limit and a long output hold-off");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[files.f]
design/clt_pkg.sv
design/clt_decode.sv
design/clt_fifo.sv
design/command_line_tokenizer_top.sv
verif/command_line_tokenizer_tb.sv
